FILE: rtl/core/bpdu_pkg.sv
// shared constants, types and byte functions of the bit-plane delta unfilter
package bpdu_pkg;

  localparam int unsigned LineBytes = 16384;
  localparam int unsigned Lanes     = 4;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned DataW     = Lanes * ByteW;
  localparam int unsigned LaneW     = $clog2(Lanes);
  localparam int unsigned AddrW     = $clog2(LineBytes);
  localparam int unsigned IdxW      = AddrW - LaneW;
  localparam int unsigned BankDepth = LineBytes / Lanes;

  localparam int unsigned ColW    = 14;
  localparam int unsigned RowW    = 16;
  localparam int unsigned StrideW = ColW + 1;
  localparam int unsigned RowIncW = RowW + 1;
  localparam int unsigned WidthW  = 13;
  localparam int unsigned HeightW = 16;
  localparam int unsigned BppW    = 3;

  localparam int unsigned MaxWidth = 4096;
  localparam int unsigned MaxBpp   = Lanes;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPixelWidth    = 2'd0,
    CfgPixelHeight   = 2'd1,
    CfgBytesPerPixel = 2'd2
  } cfg_reg_e;

  typedef logic [ByteW-1:0] byte_t;

  // regroup bit pair (2*lane+1:2*lane) of every plane byte, plane 1 on top
  function automatic byte_t gather(logic [DataW-1:0] planes, int unsigned lane);
    byte_t b;
    b = '0;
    for (int p = 0; p < Lanes; p++) begin
      b[ByteW-2-2*p +: 2] = planes[ByteW*p + 2*lane +: 2];
    end
    return b;
  endfunction

  // zigzag unpack: shift right, invert when the low bit was set
  function automatic byte_t unzigzag(byte_t v);
    byte_t r;
    r = {1'b0, v[ByteW-1:1]};
    if (v[0]) begin
      r = ~r;
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/bitplane_delta_unfilter.sv
// bit-plane regroup, zigzag unpack and row delta reconstruction, four bytes a transfer
// an accepted input transfer passes the stage 1 registers, then the output register
// throughput: one item per cycle unless output stalls; each of four line store banks
//   serves one read and one write per cycle; a line's first columns live in flip-flops
// reset: position, byte history, output valid and config (width 1, height 1, 4 bytes)
//   are cleared at once; the line store is not cleared and holds garbage until written
module bitplane_delta_unfilter (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // input stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // plane1_byte [7:0], plane2_byte [15:8], plane3_byte [23:16], plane4_byte [31:24]
  input  logic [bpdu_pkg::DataW-1:0]           s_axis_tdata,
  // output stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // out_byte0 [7:0], out_byte1 [15:8], out_byte2 [23:16], out_byte3 [31:24]
  output logic [bpdu_pkg::DataW-1:0]           m_axis_tdata,
  // image_done
  output logic                                 m_axis_tlast,
  // config write channel
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [bpdu_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [bpdu_pkg::CfgDataW-1:0]        cfg_data_i
);
  import bpdu_pkg::*;

  // config registers and their clamped values
  logic [WidthW-1:0]  pixel_width_q, width_eff;
  logic [HeightW-1:0] pixel_height_q, height_eff;
  logic [BppW-1:0]    bytes_per_pixel_q, bpp_eff;
  logic [LaneW-1:0]   bpp_m1;
  logic [StrideW-1:0] stride;

  // handshakes
  logic s_acc;
  logic s1_adv;

  // position walk of stage 0
  logic [ColW-1:0]    col_q, col_d, col_w;
  logic [RowW-1:0]    row_q, row_d, row_w;
  logic [StrideW-1:0] col_inc;
  logic [RowIncW-1:0] row_inc;
  logic               done_w;
  logic [AddrW-1:0]   lane_addr [Lanes];
  logic [Lanes-1:0]   lane_row0, lane_ge_d;
  byte_t              lane_val [Lanes];

  // bank read addresses of stage 0
  logic [AddrW-1:0]   rd_base;
  logic [LaneW-1:0]   rd_off  [Lanes];
  logic [AddrW-1:0]   rd_addr [Lanes];
  logic [IdxW-1:0]    rd_idx  [Lanes];

  // stage 1 registers
  logic               s1_valid_q;
  byte_t              s1_val_q   [Lanes];
  logic [LaneW-1:0]   s1_lo_q    [Lanes];
  logic [IdxW-1:0]    s1_idx_q   [Lanes];
  logic [Lanes-1:0]   s1_head_q, s1_row0_q, s1_ge_d_q;
  logic [Lanes-1:0]   s1_match_q [Lanes];
  logic               s1_done_q;

  // line store access
  byte_t              bank_rd    [Lanes];
  logic [Lanes-1:0]   bank_we;
  logic [IdxW-1:0]    bank_widx  [Lanes];
  byte_t              bank_wdata [Lanes];
  byte_t              head_q [Lanes], head_d [Lanes];

  // reconstruction
  logic [DataW-1:0]   recent_q, hist;
  byte_t              lane_out [Lanes];
  byte_t              pred;

  // output register
  logic               m_valid_q;
  logic [DataW-1:0]   m_data_q;
  logic               m_last_q;

  // ---------------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_width_q     <= WidthW'(1);
      pixel_height_q    <= HeightW'(1);
      bytes_per_pixel_q <= BppW'(MaxBpp);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CfgPixelWidth:    pixel_width_q     <= cfg_data_i[WidthW-1:0];
        CfgPixelHeight:   pixel_height_q    <= cfg_data_i[HeightW-1:0];
        CfgBytesPerPixel: bytes_per_pixel_q <= cfg_data_i[BppW-1:0];
        default: ;
      endcase
    end
  end

  // out-of-range settings fold onto the nearest legal value
  always_comb begin
    if (pixel_width_q == '0) begin
      width_eff = WidthW'(1);
    end else if (pixel_width_q > WidthW'(MaxWidth)) begin
      width_eff = WidthW'(MaxWidth);
    end else begin
      width_eff = pixel_width_q;
    end
    height_eff = (pixel_height_q == '0) ? HeightW'(1) : pixel_height_q;
    if (bytes_per_pixel_q == '0) begin
      bpp_eff = BppW'(1);
    end else if (bytes_per_pixel_q > BppW'(MaxBpp)) begin
      bpp_eff = BppW'(MaxBpp);
    end else begin
      bpp_eff = bytes_per_pixel_q;
    end
    bpp_m1 = LaneW'(bpp_eff - BppW'(1));
    stride = StrideW'(width_eff) * StrideW'(bpp_eff);
  end

  // ---------------------------------------------------------------------------
  // handshake: stage 1 drains into the output register when it is free
  // ---------------------------------------------------------------------------
  assign s1_adv        = s1_valid_q && (!m_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------------------
  // stage 0: walk the four byte positions, row and image ends may fall mid-item
  // ---------------------------------------------------------------------------
  always_comb begin
    col_w   = col_q;
    row_w   = row_q;
    done_w  = 1'b0;
    col_inc = '0;
    row_inc = '0;
    for (int j = 0; j < Lanes; j++) begin
      lane_addr[j] = AddrW'(col_w);
      lane_row0[j] = (row_w == '0);
      lane_ge_d[j] = (col_w >= ColW'(bpp_eff));
      lane_val[j]  = unzigzag(gather(s_axis_tdata, j));
      col_inc      = {1'b0, col_w} + StrideW'(1);
      if (col_inc >= stride) begin
        col_w   = '0;
        row_inc = {1'b0, row_w} + RowIncW'(1);
        if (row_inc >= {1'b0, height_eff}) begin
          row_w  = '0;
          done_w = 1'b1;
        end else begin
          row_w = row_inc[RowW-1:0];
        end
      end else begin
        col_w = col_inc[ColW-1:0];
      end
    end
    col_d = col_w;
    row_d = row_w;
  end

  // bytes that reach the banks sit at consecutive addresses from the item's first
  // column, so each bank is read once at the address among those four that it owns
  always_comb begin
    rd_base = AddrW'(col_q);
    for (int k = 0; k < Lanes; k++) begin
      rd_off[k]  = LaneW'(k) - rd_base[LaneW-1:0];
      rd_addr[k] = rd_base + AddrW'(rd_off[k]);
      rd_idx[k]  = rd_addr[k][AddrW-1:LaneW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (s_acc) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (s_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      for (int j = 0; j < Lanes; j++) begin
        s1_val_q[j]  <= lane_val[j];
        s1_lo_q[j]   <= lane_addr[j][LaneW-1:0];
        s1_idx_q[j]  <= lane_addr[j][AddrW-1:LaneW];
        s1_head_q[j] <= (lane_addr[j][AddrW-1:LaneW] == '0);
        s1_row0_q[j] <= lane_row0[j];
        s1_ge_d_q[j] <= lane_ge_d[j];
        for (int k = 0; k < Lanes; k++) begin
          s1_match_q[j][k] <= (k < j) && (lane_addr[j] == lane_addr[k]);
        end
      end
      s1_done_q <= done_w;
    end
  end

  // ---------------------------------------------------------------------------
  // line store: four banks by column low bits, one read and one write each per
  // cycle; a write in the cycle of a read is forwarded on the next cycle
  // ---------------------------------------------------------------------------
  for (genvar k = 0; k < Lanes; k++) begin : g_bank
    byte_t mem_q [BankDepth];
    byte_t rd_data_q;
    logic  byp_hit_q;
    byte_t byp_data_q;

    always_ff @(posedge clk_i) begin
      if (bank_we[k]) begin
        mem_q[bank_widx[k]] <= bank_wdata[k];
      end
      if (s_acc) begin
        rd_data_q  <= mem_q[rd_idx[k]];
        byp_hit_q  <= bank_we[k] && (bank_widx[k] == rd_idx[k]);
        byp_data_q <= bank_wdata[k];
      end
    end

    assign bank_rd[k] = byp_hit_q ? byp_data_q : rd_data_q;
  end

  // ---------------------------------------------------------------------------
  // stage 1: predict and add; row 0 looks back in the byte stream, later rows
  // take the line store, with bytes of this same item forwarded first
  // ---------------------------------------------------------------------------
  always_comb begin
    hist = recent_q;
    pred = '0;
    for (int j = 0; j < Lanes; j++) begin
      if (s1_row0_q[j]) begin
        pred = s1_ge_d_q[j] ? hist[ByteW*bpp_m1 +: ByteW] : '0;
      end else begin
        pred = s1_head_q[j] ? head_q[s1_lo_q[j]] : bank_rd[s1_lo_q[j]];
        for (int k = 0; k < j; k++) begin
          if (s1_match_q[j][k]) begin
            pred = lane_out[k];
          end
        end
      end
      lane_out[j] = s1_val_q[j] + pred;
      hist        = {hist[DataW-ByteW-1:0], lane_out[j]};
    end
  end

  // store write-back, the later byte wins where a short row repeats a column
  always_comb begin
    for (int k = 0; k < Lanes; k++) begin
      bank_we[k]    = 1'b0;
      bank_widx[k]  = '0;
      bank_wdata[k] = '0;
      head_d[k]     = head_q[k];
      for (int j = 0; j < Lanes; j++) begin
        if (s1_lo_q[j] == LaneW'(k)) begin
          if (s1_head_q[j]) begin
            head_d[k] = lane_out[j];
          end else begin
            bank_we[k]    = s1_adv;
            bank_widx[k]  = s1_idx_q[j];
            bank_wdata[k] = lane_out[j];
          end
        end
      end
    end
  end

  // first columns of the line in flip-flops
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      head_q <= head_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recent_q  <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        recent_q <= hist;
      end
      if (s1_adv) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      for (int j = 0; j < Lanes; j++) begin
        m_data_q[ByteW*j +: ByteW] <= lane_out[j];
      end
      m_last_q <= s1_done_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

endmodule

FILE: rtl/core/bpdu_checker.sv
// port-level checks of the bit-plane delta unfilter and their bind
module bpdu_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [bpdu_pkg::DataW-1:0]    m_axis_tdata,
  input logic                          m_axis_tlast
);
  logic s_acc;
  assign s_acc = s_axis_tvalid && s_axis_tready;

  // output side quiet while in reset
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("result shown during reset");

  // nothing pending on the output means the input side takes a transfer
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output register");

  // every accepted transfer has a result waiting once it has passed the stage 1 and output registers
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> ##1 m_axis_tvalid)
    else $error("result missing two cycles after input transfer");

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

endmodule

bind bitplane_delta_unfilter bpdu_checker u_bpdu_checker (.*);
